@@ design/smc_pkg.sv @@
// Shared types, constants and helper functions of the sprite mask collision block.
// No dependencies; smc_ctrl, smc_dp, the top and the testbench import this package.
package smc_pkg;

    localparam int MAX_ROWS_DEF  = 128;
    localparam int ROW_WORDS_DEF = 4;
    localparam int STEP_W        = 6;
    localparam int DIM_W         = 8;

    localparam logic [1:0] ACT_LOAD_A = 2'd0;
    localparam logic [1:0] ACT_LOAD_B = 2'd1;
    localparam logic [1:0] ACT_TEST   = 2'd2;

    localparam logic [1:0] REG_WIDTH_A  = 2'd0;
    localparam logic [1:0] REG_HEIGHT_A = 2'd1;
    localparam logic [1:0] REG_WIDTH_B  = 2'd2;
    localparam logic [1:0] REG_HEIGHT_B = 2'd3;

    typedef struct packed {
        logic [1:0]         action;
        logic [6:0]         row;
        logic [1:0]         word_index;
        logic [31:0]        word_data;
        logic signed [15:0] pos_ax;
        logic signed [15:0] pos_ay;
        logic signed [15:0] pos_bx;
        logic signed [15:0] pos_by;
    } t_in;

    typedef struct packed {
        logic hit;
        logic boxes_overlap;
    } t_out;

    typedef struct packed {
        logic              load;
        logic              latch;
        logic              box;
        logic              setup;
        logic              issue;
        logic [DIM_W-1:0]  row;
        logic [STEP_W-1:0] step;
    } t_cmd;

    typedef struct packed {
        logic              overlap;
        logic [DIM_W-1:0]  ih;
        logic [STEP_W-1:0] na;
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BOX,
        ST_SETUP,
        ST_WALK,
        ST_DRAIN,
        ST_DONE
    } t_state;

    function automatic logic [31:0] clip_word(logic [31:0] data, logic [15:0] start,
                                              logic [15:0] w);
        logic [15:0] d;
        d = w - start;
        if (w <= start) begin
            clip_word = 32'h0000_0000;
        end else if (d >= 16'd32) begin
            clip_word = data;
        end else begin
            clip_word = data & (32'hFFFF_FFFF << (6'd32 - d[5:0]));
        end
    endfunction

endpackage

@@ design/smc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module smc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ design/smc_ctrl.sv @@
// Sequencer of the sprite mask collision block: loads, box test and row/word walk.
// Depends on smc_pkg.
module smc_ctrl import smc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_action,
    input  t_status    i_status,
    output t_cmd       o_cmd,
    output logic       o_busy,
    output logic       o_strobe
);
    t_state            r_state, n_state;
    logic [DIM_W-1:0]  r_row, n_row;
    logic [STEP_W-1:0] r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_row   <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_row        = r_row;
        n_step       = r_step;
        o_cmd        = '0;
        o_cmd.row    = r_row;
        o_cmd.step   = r_step;
        o_busy       = (r_state != ST_IDLE);
        o_strobe     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = (i_action == ACT_LOAD_A) || (i_action == ACT_LOAD_B);
                    if (i_action == ACT_TEST) begin
                        o_cmd.latch = 1'b1;
                        n_state     = ST_BOX;
                    end
                end
            end
            ST_BOX: begin
                o_cmd.box = 1'b1;
                n_state   = ST_SETUP;
            end
            ST_SETUP: begin
                o_cmd.setup = 1'b1;
                n_row       = '0;
                n_step      = '0;
                n_state     = i_status.overlap ? ST_WALK : ST_DONE;
            end
            ST_WALK: begin
                o_cmd.issue = 1'b1;
                if (r_step == i_status.na) begin
                    n_step = '0;
                    if (r_row == i_status.ih - 8'd1) begin
                        n_state = ST_DRAIN;
                    end else begin
                        n_row = r_row + 8'd1;
                    end
                end else begin
                    n_step = r_step + 6'd1;
                end
            end
            ST_DRAIN: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                o_strobe = 1'b1;
                n_state  = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end
endmodule

@@ design/smc_dp.sv @@
// Datapath of the sprite mask collision block: registers, mask RAMs, geometry and compare.
// Depends on smc_pkg and smc_ram.
module smc_dp import smc_pkg::*; #(
    parameter int MAX_ROWS  = MAX_ROWS_DEF,
    parameter int ROW_WORDS = ROW_WORDS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_wdata,
    input  t_in        i_in,
    input  t_cmd       i_cmd,
    output t_status    o_status,
    output t_out       o_out
);
    localparam int DEPTH     = MAX_ROWS * ROW_WORDS;
    localparam int AW        = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int MAX_WIDTH = ROW_WORDS * 32;

    logic [7:0] r_width_a, r_height_a, r_width_b, r_height_b;
    logic [7:0] wa, ha, wb, hb, wl, wr;

    logic signed [15:0] r_ax, r_ay, r_bx, r_by;
    logic signed [17:0] r_axe, r_aye, r_bxe, r_bye;
    logic               r_overlap, r_hit;
    logic [7:0]         r_ih, r_ry, r_ly;
    logic [STEP_W-1:0]  r_na;
    logic               r_tail, r_a_right;
    logic [4:0]         r_sb;
    logic [2:0]         r_sw;

    logic               r_tv, r_tlv;
    logic [STEP_W-1:0]  r_tstep;
    logic [7:0]         r_tlw;
    logic [31:0]        r_ma, r_mb;

    logic signed [15:0] ix, iy;
    logic signed [17:0] ex, ey;
    logic [7:0]         iw, lx;
    logic [9:0]         nb;
    logic [STEP_W-1:0]  na;

    logic [7:0]         rrow, lrow, lword;
    logic [STEP_W-1:0]  rword;
    logic               lvalid, load_ok;
    logic [AW-1:0]      raddr, laddr, waddr;
    logic [31:0]        qa, qb, cur_r, cur_l, nxt, ld_data_a, ld_data_b;
    logic               use_nxt, pair_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_a  <= '0;
            r_height_a <= '0;
            r_width_b  <= '0;
            r_height_b <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WIDTH_A:  r_width_a  <= i_cfg_wdata;
                REG_HEIGHT_A: r_height_a <= i_cfg_wdata;
                REG_WIDTH_B:  r_width_b  <= i_cfg_wdata;
                REG_HEIGHT_B: r_height_b <= i_cfg_wdata;
                default:      r_width_a  <= r_width_a;
            endcase
        end
    end

    assign wa = (int'(r_width_a)  > MAX_WIDTH) ? 8'(MAX_WIDTH) : r_width_a;
    assign wb = (int'(r_width_b)  > MAX_WIDTH) ? 8'(MAX_WIDTH) : r_width_b;
    assign ha = (int'(r_height_a) > MAX_ROWS)  ? 8'(MAX_ROWS)  : r_height_a;
    assign hb = (int'(r_height_b) > MAX_ROWS)  ? 8'(MAX_ROWS)  : r_height_b;
    assign wr = r_a_right ? wa : wb;
    assign wl = r_a_right ? wb : wa;

    // geometry of the box intersection
    assign ix = (r_ax > r_bx) ? r_ax : r_bx;
    assign iy = (r_ay > r_by) ? r_ay : r_by;
    assign ex = (r_axe < r_bxe) ? r_axe : r_bxe;
    assign ey = (r_aye < r_bye) ? r_aye : r_bye;
    assign iw = 8'(ex - 18'(ix));
    assign lx = 8'(ix - ((r_ax > r_bx) ? r_bx : r_ax));
    assign na = STEP_W'((9'(iw) + 9'd31) >> 5);
    assign nb = (10'(iw) + 10'(lx[4:0]) + 10'd31) >> 5;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_ax <= i_in.pos_ax;
            r_ay <= i_in.pos_ay;
            r_bx <= i_in.pos_bx;
            r_by <= i_in.pos_by;
        end
        if (i_cmd.box) begin
            r_axe     <= 18'(r_ax) + 18'(wa);
            r_aye     <= 18'(r_ay) + 18'(ha);
            r_bxe     <= 18'(r_bx) + 18'(wb);
            r_bye     <= 18'(r_by) + 18'(hb);
        end
        if (i_cmd.setup) begin
            r_ih      <= 8'(ey - 18'(iy));
            r_na      <= na;
            r_tail    <= nb > 10'(na);
            r_sb      <= lx[4:0];
            r_sw      <= lx[7:5];
            r_a_right <= r_ax > r_bx;
            r_ry      <= 8'(iy - ((r_ax > r_bx) ? r_ay : r_by));
            r_ly      <= 8'(iy - ((r_ax > r_bx) ? r_by : r_ay));
        end
        if (i_cmd.issue) begin
            r_tstep <= i_cmd.step;
            r_tlv   <= lvalid;
            r_tlw   <= lword;
        end
        if (r_tv) begin
            r_ma <= cur_r;
            r_mb <= cur_l;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tv      <= 1'b0;
            r_overlap <= 1'b0;
            r_hit     <= 1'b0;
        end else begin
            r_tv <= i_cmd.issue;
            if (i_cmd.box) begin
                r_overlap <= (wa != 8'd0) && (ha != 8'd0) && (wb != 8'd0) && (hb != 8'd0)
                    && ($signed(18'(r_ax)) < $signed(18'(r_bx) + 18'(wb)))
                    && ($signed(18'(r_bx)) < $signed(18'(r_ax) + 18'(wa)))
                    && ($signed(18'(r_ay)) < $signed(18'(r_by) + 18'(hb)))
                    && ($signed(18'(r_by)) < $signed(18'(r_ay) + 18'(ha)));
            end
            if (i_cmd.latch) begin
                r_hit <= 1'b0;
            end else if (pair_hit) begin
                r_hit <= 1'b1;
            end
        end
    end

    // read addresses for one walk step
    assign rrow   = r_ry + i_cmd.row;
    assign lrow   = r_ly + i_cmd.row;
    assign rword  = (i_cmd.step < r_na) ? i_cmd.step : '0;
    assign lword  = 8'(i_cmd.step) + 8'(r_sw);
    assign lvalid = lword < 8'(ROW_WORDS);
    assign raddr  = AW'(32'(rrow) * ROW_WORDS + 32'(rword));
    assign laddr  = AW'(32'(lrow) * ROW_WORDS + 32'(lvalid ? lword : 8'd0));

    assign load_ok   = (32'(i_in.row) < MAX_ROWS) && (32'(i_in.word_index) < ROW_WORDS);
    assign waddr     = AW'(32'(i_in.row) * ROW_WORDS + 32'(i_in.word_index));
    assign ld_data_a = clip_word(i_in.word_data, 16'(i_in.word_index) << 5, 16'(wa));
    assign ld_data_b = clip_word(i_in.word_data, 16'(i_in.word_index) << 5, 16'(wb));

    smc_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load && (i_in.action == ACT_LOAD_A) && load_ok),
        .i_waddr (waddr),
        .i_wdata (ld_data_a),
        .i_raddr (r_a_right ? raddr : laddr),
        .o_rdata (qa)
    );

    smc_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load && (i_in.action == ACT_LOAD_B) && load_ok),
        .i_waddr (waddr),
        .i_wdata (ld_data_b),
        .i_raddr (r_a_right ? laddr : raddr),
        .o_rdata (qb)
    );

    // compare the previous word pair against the newly read left word
    assign cur_r    = clip_word(r_a_right ? qa : qb, 16'(r_tstep) << 5, 16'(wr));
    assign cur_l    = r_tlv ? clip_word(r_a_right ? qb : qa, 16'(r_tlw) << 5, 16'(wl))
                            : 32'h0000_0000;
    assign use_nxt  = (r_sb != 5'd0) && ((r_tstep < r_na) || r_tail);
    assign nxt      = use_nxt ? (cur_l >> (6'd32 - {1'b0, r_sb})) : 32'h0000_0000;
    assign pair_hit = r_tv && (r_tstep != '0)
                      && (|(((r_ma >> r_sb) & r_mb) | (r_ma & nxt)));

    assign o_status.overlap   = r_overlap;
    assign o_status.ih        = r_ih;
    assign o_status.na        = r_na;
    assign o_out.hit           = r_hit;
    assign o_out.boxes_overlap = r_overlap;
endmodule

@@ design/sprite_mask_collision.sv @@
// Pixel-exact collision test between two sprite opacity masks held in on-chip RAM.
// A load word is written while idle and gives no result. A test word runs the states box,
// setup, walk, drain and done with overlapping boxes (IH rows of the box intersection,
// NA = ceil(intersection width / 32) words per row) and box, setup and done otherwise; the walk
// reads one right-hand and one left-hand mask word per cycle, one read port per mask RAM.
// busy stays high for the whole test; the result appears for one cycle with o_strobe
// and must be taken then. Depends on smc_pkg, smc_ctrl, smc_dp and smc_ram.
module sprite_mask_collision import smc_pkg::*; #(
    parameter int MAX_ROWS  = MAX_ROWS_DEF,
    parameter int ROW_WORDS = ROW_WORDS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_in        i_in,
    output logic       o_strobe,
    output t_out       o_out,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_wdata
);
    t_cmd    cmd;
    t_status status;

    smc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_in.action),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_strobe (o_strobe)
    );

    smc_dp #(.MAX_ROWS(MAX_ROWS), .ROW_WORDS(ROW_WORDS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out       (o_out)
    );

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy) else $error("result word outside a test");

    a_hit_needs_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_out.boxes_overlap |-> !o_out.hit) else $error("hit without box overlap");

    a_test_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_in.action == ACT_TEST |=> busy && !o_strobe)
        else $error("test word not taken");

    a_load_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_in.action != ACT_TEST |=> !busy) else $error("load word held busy");
endmodule

@@ sim/sprite_mask_collision_tb.sv @@
// Self-checking testbench for sprite_mask_collision: directed table, then random words.
// Expected results come from a behavioral collision predictor. Depends on smc_pkg and sprite_mask_collision.
module sprite_mask_collision_tb;
    import smc_pkg::*;

    localparam logic [1:0] ACT_IGNORED = 2'd3;
    localparam int DEPTH = MAX_ROWS_DEF * ROW_WORDS_DEF;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int RANDOM_WORDS = 124;
    localparam int IN_W = $bits(t_in);

    typedef struct {
        t_in  word;
        bit   typed;
        t_out want;
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    t_in        i_in = '0;
    logic       o_strobe;
    t_out       o_out;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = '0;
    logic [7:0] i_cfg_wdata = '0;

    logic [31:0] masks_a[DEPTH];
    logic [31:0] masks_b[DEPTH];
    int unsigned dim_w_a, dim_h_a, dim_w_b, dim_h_b;
    t_out        pending[$];
    int          fails = 0;
    int          idle_pct = 0;
    longint      cycles = 0;

    sprite_mask_collision DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_in(i_in),
        .o_strobe(o_strobe), .o_out(o_out), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [31:0] clip_pixels(logic [31:0] d, int unsigned wi,
                                                int unsigned w);
        int unsigned s;
        s = wi * 32;
        if (w <= s) return 32'h0000_0000;
        if (w - s >= 32) return d;
        return d & (32'hFFFF_FFFF << (32 - (w - s)));
    endfunction

    function automatic logic [31:0] mask_word(bit sel_b, int unsigned r, int unsigned wi,
                                              int unsigned w);
        if (r >= MAX_ROWS_DEF || wi >= ROW_WORDS_DEF) return 32'h0000_0000;
        return clip_pixels(sel_b ? masks_b[r * ROW_WORDS_DEF + wi]
                                 : masks_a[r * ROW_WORDS_DEF + wi], wi, w);
    endfunction

    function automatic int unsigned sat(int unsigned v, int unsigned lim);
        return v > lim ? lim : v;
    endfunction

    // update the masks for loads; return 1 with the collision verdict for tests
    function automatic bit collide(t_in w, output t_out r);
        int unsigned wa, ha, wb, hb, wr, wl, ry, ly, lx, iw, ih, sw, sb, na, nb, idx;
        int ax, ay, bx, by, ix, iy;
        bit rb, ov, h;
        logic [31:0] ma, mb, nx;
        wa = sat(dim_w_a, 128); ha = sat(dim_h_a, 128);
        wb = sat(dim_w_b, 128); hb = sat(dim_h_b, 128);
        r = '0;
        if (w.action == ACT_LOAD_A || w.action == ACT_LOAD_B) begin
            idx = w.row * ROW_WORDS_DEF + w.word_index;
            if (w.action == ACT_LOAD_A) masks_a[idx] = clip_pixels(w.word_data, w.word_index, wa);
            else masks_b[idx] = clip_pixels(w.word_data, w.word_index, wb);
            return 1'b0;
        end
        if (w.action != ACT_TEST) return 1'b0;
        ax = w.pos_ax; ay = w.pos_ay; bx = w.pos_bx; by = w.pos_by;
        ov = wa > 0 && ha > 0 && wb > 0 && hb > 0 && ax < bx + int'(wb) && bx < ax + int'(wa)
             && ay < by + int'(hb) && by < ay + int'(ha);
        h = 1'b0;
        if (ov) begin
            ix = ax > bx ? ax : bx;
            iy = ay > by ? ay : by;
            iw = ((ax + int'(wa)) < (bx + int'(wb)) ? ax + int'(wa) : bx + int'(wb)) - ix;
            ih = ((ay + int'(ha)) < (by + int'(hb)) ? ay + int'(ha) : by + int'(hb)) - iy;
            rb = !(ax > bx);
            if (ax > bx) begin
                wr = wa; ry = iy - ay; wl = wb; ly = iy - by; lx = ix - bx;
            end else begin
                wr = wb; ry = iy - by; wl = wa; ly = iy - ay; lx = ix - ax;
            end
            sw = lx >> 5; sb = lx & 31;
            na = (iw + 31) >> 5; nb = (iw + sb + 31) >> 5;
            for (int unsigned i = 0; i < ih && !h; i++) begin
                for (int unsigned j = 0; j < na && !h; j++) begin
                    ma = mask_word(rb, ry + i, j, wr);
                    mb = mask_word(!rb, ly + i, j + sw, wl);
                    nx = '0;
                    if (sb != 0 && (j + 1 < na || nb > na))
                        nx = mask_word(!rb, ly + i, j + sw + 1, wl) >> (32 - sb);
                    if ((((ma >> sb) & mb) | (ma & nx)) != 0) h = 1'b1;
                end
            end
        end
        r.hit = h;
        r.boxes_overlap = ov;
        return 1'b1;
    endfunction

    function automatic t_in test_word(int ax, int ay, int bx, int by);
        t_in w;
        w = '0;
        w.action = ACT_TEST;
        w.pos_ax = ax[15:0]; w.pos_ay = ay[15:0]; w.pos_bx = bx[15:0]; w.pos_by = by[15:0];
        return w;
    endfunction

    function automatic t_in load_word(logic [1:0] act, int r, int wi, logic [31:0] d);
        t_in w;
        w = '0;
        w.action = act; w.row = r[6:0]; w.word_index = wi[1:0]; w.word_data = d;
        return w;
    endfunction

    task automatic send(t_in w, bit typed, t_out want);
        t_out r;
        i_in <= w;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        if (collide(w, r)) pending.push_back(typed ? want : r);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    task automatic set_dims(int wa, int ha, int wb, int hb);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= REG_WIDTH_A;  i_cfg_wdata <= wa[7:0]; @(posedge i_clk); dim_w_a = wa;
        i_cfg_idx <= REG_HEIGHT_A; i_cfg_wdata <= ha[7:0]; @(posedge i_clk); dim_h_a = ha;
        i_cfg_idx <= REG_WIDTH_B;  i_cfg_wdata <= wb[7:0]; @(posedge i_clk); dim_w_b = wb;
        i_cfg_idx <= REG_HEIGHT_B; i_cfg_wdata <= hb[7:0]; @(posedge i_clk); dim_h_b = hb;
        i_cfg_we <= 1'b0;
    endtask

    function automatic int pick_dim();
        int opts[10] = '{0, 1, 31, 32, 33, 64, 100, 128, 200, 255};
        return $urandom_range(3) == 0 ? opts[$urandom_range(9)] : $urandom_range(1, 128);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (pending.size() == 0) begin
                $error("unexpected result: hit %0d boxes_overlap %0d", o_out.hit,
                       o_out.boxes_overlap);
                fails++;
            end else begin
                if (o_out.hit !== pending[0].hit) begin
                    $error("hit: expected %0d, got %0d", pending[0].hit, o_out.hit);
                    fails++;
                end
                if (o_out.boxes_overlap !== pending[0].boxes_overlap) begin
                    $error("boxes_overlap: expected %0d, got %0d",
                           pending[0].boxes_overlap, o_out.boxes_overlap);
                    fails++;
                end
                void'(pending.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("sprite_mask_collision_tb failed");
            $finish;
        end
    end

    initial begin
        t_row   rows[$];
        t_in    w;
        t_out   none;
        int     ax, ay, dx, dy, k;
        none = '0;
        dim_w_a = 0; dim_h_a = 0; dim_w_b = 0; dim_h_b = 0;
        foreach (masks_a[i]) begin
            masks_a[i] = '0;
            masks_b[i] = '0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty sprites after reset, ignored action
        send(test_word(0, 0, 0, 0), 1'b1, none);
        w = test_word(0, 0, 0, 0);
        w.action = ACT_IGNORED;
        send(w, 1'b0, none);

        // fill every mask word once so no test reads an unwritten word
        set_dims(128, 128, 128, 128);
        for (int i = 0; i < DEPTH; i++) begin
            send(load_word(ACT_LOAD_A, i / 4, i % 4, $urandom & $urandom), 1'b0, none);
            send(load_word(ACT_LOAD_B, i / 4, i % 4, $urandom & $urandom), 1'b0, none);
        end

        rows.push_back('{test_word(0, 0, 0, 0), 1'b0, none});
        rows.push_back('{test_word(0, 0, 128, 0), 1'b1, none});
        rows.push_back('{test_word(0, 0, -128, 0), 1'b1, none});
        rows.push_back('{test_word(0, 0, 0, 128), 1'b1, none});
        rows.push_back('{test_word(-32768, -32768, 32767, 32767), 1'b1, none});
        rows.push_back('{test_word(32767, 32767, -32768, -32768), 1'b1, none});
        rows.push_back('{test_word(0, 0, 32, 0), 1'b0, none});
        rows.push_back('{test_word(64, 3, 0, 0), 1'b0, none});
        rows.push_back('{test_word(0, 0, 5, -3), 1'b0, none});
        rows.push_back('{test_word(0, 0, 127, 127), 1'b0, none});
        rows.push_back('{load_word(ACT_LOAD_A, 0, 0, 32'hFFFF_FFFF), 1'b0, none});
        rows.push_back('{load_word(ACT_LOAD_B, 127, 3, 32'hFFFF_FFFF), 1'b0, none});
        rows.push_back('{load_word(ACT_LOAD_B, 0, 0, 32'h0000_0000), 1'b0, none});
        rows.push_back('{test_word(0, 0, 0, 0), 1'b0, none});
        rows.push_back('{test_word(127, 127, 0, 0), 1'b0, none});
        rows.push_back('{test_word(-1, -1, 0, 0), 1'b0, none});
        foreach (rows[i]) send(rows[i].word, rows[i].typed, rows[i].want);

        // saturated and narrow sizes, stale pixels past the width
        set_dims(255, 255, 40, 1);
        send(load_word(ACT_LOAD_B, 0, 1, 32'hFFFF_FFFF), 1'b0, none);
        send(test_word(0, 0, 90, 127), 1'b0, none);
        send(test_word(0, 0, -39, 0), 1'b0, none);
        send(test_word(0, 0, -40, 0), 1'b1, none);

        for (int ph = 0; ph < 4; ph++) begin
            set_dims(pick_dim(), pick_dim(), pick_dim(), pick_dim());
            idle_pct = ph == 1 ? 74 : (ph == 3 ? 10 : 0);
            for (int n = 0; n < RANDOM_WORDS / 4; n++) begin
                k = $urandom_range(99);
                if (k < 35) begin
                    w = load_word($urandom_range(1) ? ACT_LOAD_A : ACT_LOAD_B, $urandom_range(127),
                                  $urandom_range(3), $urandom_range(1) ? $urandom
                                                                       : ($urandom & $urandom));
                end else if (k < 90) begin
                    ax = $urandom_range(65535) - 32768;
                    ay = $urandom_range(65535) - 32768;
                    dx = $urandom_range(3) == 0 ? 32 * ($urandom_range(8) - 4)
                                                : $urandom_range(280) - 140;
                    dy = $urandom_range(280) - 140;
                    w = test_word(ax, ay, ax + dx, ay + dy);
                end else if (k < 95) begin
                    w = test_word($urandom, $urandom, $urandom, $urandom);
                end else begin
                    w = t_in'(IN_W'({$urandom, $urandom, $urandom, $urandom}));
                    w.action = ACT_IGNORED;
                end
                send(w, 1'b0, none);
            end
        end

        start <= 1'b0;
        idle_pct = 0;
        while (pending.size() != 0) @(posedge i_clk);
        repeat (700) @(posedge i_clk);
        if (fails == 0 && pending.size() == 0) begin
            $display("sprite_mask_collision_tb passed");
        end else begin
            $display("sprite_mask_collision_tb failed");
        end
        $finish;
    end
endmodule

@@ files.f @@
design/smc_pkg.sv
design/smc_ram.sv
design/smc_ctrl.sv
design/smc_dp.sv
design/sprite_mask_collision.sv
sim/sprite_mask_collision_tb.sv
